@@ rtl/core/pee_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pee_pkg;

    localparam int DATA_W      = 32;
    localparam int STACK_DEPTH = 64;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
    localparam int DIV_CNT_W   = $clog2(DATA_W);

    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [2:0] OP_NOP  = 3'd0;
    localparam logic [2:0] OP_PUSH = 3'd1;
    localparam logic [2:0] OP_ADD  = 3'd2;
    localparam logic [2:0] OP_SUB  = 3'd3;
    localparam logic [2:0] OP_MUL  = 3'd4;
    localparam logic [2:0] OP_DIV  = 3'd5;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_UNDER = 2'd1;
    localparam logic [1:0] ERR_DIV0  = 2'd2;
    localparam logic [1:0] ERR_OVER  = 2'd3;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] digit;
        logic       last;
    } pee_cmd_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

    // Only the first error of an expression is kept.
    function automatic logic [1:0] note_err(input logic [1:0] cur, input logic [1:0] code);
        return (cur == ERR_NONE) ? code : cur;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pee_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pee_front
    import pee_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    output logic            char_stall,
    input  wire logic [7:0] char_code,
    input  wire logic       last_char,
    output logic            cmd_push,
    output pee_cmd_t        cmd_data,
    input  wire logic       cmd_full
);

    logic     front_valid_reg;
    logic     front_valid_next;
    pee_cmd_t front_cmd_reg;
    pee_cmd_t front_cmd_next;
    pee_cmd_t cls_cmd;
    logic     accept;
    logic     keep;

    always_comb
    begin
        cls_cmd.digit = char_code[3:0];
        cls_cmd.last  = last_char;
        unique case (char_code) inside
            [CH_0:CH_9]: cls_cmd.op = OP_PUSH;
            CH_PLUS:     cls_cmd.op = OP_ADD;
            CH_MINUS:    cls_cmd.op = OP_SUB;
            CH_STAR:     cls_cmd.op = OP_MUL;
            CH_SLASH:    cls_cmd.op = OP_DIV;
            default:     cls_cmd.op = OP_NOP;
        endcase
    end

    // Ignored characters are dropped here unless they close the expression.
    assign keep       = (cls_cmd.op != OP_NOP) || last_char;
    assign cmd_push   = front_valid_reg && !cmd_full;
    assign char_stall = front_valid_reg && cmd_full;
    assign accept     = char_valid && !char_stall;
    assign cmd_data   = front_cmd_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_cmd_next   = front_cmd_reg;
        if (cmd_push)
        begin
            front_valid_next = 1'b0;
        end
        if (accept && keep)
        begin
            front_valid_next = 1'b1;
            front_cmd_next   = cls_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_cmd_reg <= front_cmd_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/pee_cmd_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pee_cmd_fifo
    import pee_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire pee_cmd_t push_data,
    output logic          full,
    input  wire logic     pop,
    output pee_cmd_t      pop_data,
    output logic          not_empty
);

    pee_cmd_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg;
    logic [FIFO_CW-1:0]   count_next;

    assign full      = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? FIFO_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? FIFO_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = FIFO_CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = FIFO_CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pee_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pee_divider
    import pee_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    quo_next;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    rem_next;
    logic [DATA_W-1:0]    dvs_reg;
    logic [DATA_W-1:0]    dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DATA_W:0]      rem_shift;
    logic [DATA_W:0]      diff;

    // Restoring division, one quotient bit per cycle.
    assign rem_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign diff      = rem_shift - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start && !busy_reg)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = DIV_CNT_W'(cnt_reg + 1'b1);
            if (cnt_reg == DIV_CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

@@ rtl/core/pee_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pee_back
    import pee_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    input  wire pee_cmd_t          cmd_in,
    output logic                   cmd_pop,
    output div_req_t               div_req,
    input  wire div_rsp_t          div_rsp,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output logic [DATA_W-1:0]      value,
    output logic [1:0]             error_code
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_POP_R  = 4'd1;
    localparam logic [3:0] S_POP_L  = 4'd2;
    localparam logic [3:0] S_LOAD_L = 4'd3;
    localparam logic [3:0] S_ALU    = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_PUSH   = 4'd6;
    localparam logic [3:0] S_FINISH = 4'd7;
    localparam logic [3:0] S_EMIT   = 4'd8;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    pee_cmd_t            cmd_reg;
    pee_cmd_t            cmd_next;
    logic [STACK_CW-1:0] count_reg;
    logic [STACK_CW-1:0] count_next;
    logic [1:0]          err_reg;
    logic [1:0]          err_next;
    logic                empty_reg;
    logic                empty_next;
    logic                neg_reg;
    logic                neg_next;
    logic                result_valid_reg;
    logic                result_valid_next;
    logic [DATA_W-1:0]   rhs_reg;
    logic [DATA_W-1:0]   rhs_next;
    logic [DATA_W-1:0]   lhs_reg;
    logic [DATA_W-1:0]   lhs_next;
    logic [DATA_W-1:0]   res_reg;
    logic [DATA_W-1:0]   res_next;
    logic [DATA_W-1:0]   value_reg;
    logic [DATA_W-1:0]   value_next;
    logic [1:0]          error_reg;
    logic [1:0]          error_next;

    logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   mem_q_reg;
    logic                mem_we;
    logic [STACK_AW-1:0] rd_addr;
    logic [STACK_AW-1:0] wr_addr;
    logic [DATA_W-1:0]   mag_l;
    logic [DATA_W-1:0]   mag_r;
    logic                out_free;

    // The read port always looks at the current top entry.
    assign rd_addr  = STACK_AW'(count_reg - 1'b1);
    assign wr_addr  = count_reg[STACK_AW-1:0];
    assign out_free = !result_valid_reg || !result_stall;
    assign mag_l    = lhs_reg[DATA_W-1] ? (DATA_W'(0) - lhs_reg) : lhs_reg;
    assign mag_r    = rhs_reg[DATA_W-1] ? (DATA_W'(0) - rhs_reg) : rhs_reg;

    always_comb
    begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        count_next        = count_reg;
        err_next          = err_reg;
        empty_next        = empty_reg;
        neg_next          = neg_reg;
        rhs_next          = rhs_reg;
        lhs_next          = lhs_reg;
        res_next          = res_reg;
        value_next        = value_reg;
        error_next        = error_reg;
        result_valid_next = result_valid_reg && result_stall;
        cmd_pop           = 1'b0;
        mem_we            = 1'b0;
        div_req.start     = 1'b0;
        div_req.dividend  = mag_l;
        div_req.divisor   = mag_r;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_in;
                    res_next = DATA_W'(cmd_in.digit);
                    case (cmd_in.op) inside
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_next = S_POP_R;
                        OP_PUSH:                        state_next = S_PUSH;
                        default:                        state_next = S_FINISH;
                    endcase
                end
            end
            S_POP_R:
            begin
                empty_next = (count_reg == '0);
                if (count_reg == '0)
                begin
                    err_next = note_err(err_reg, ERR_UNDER);
                end
                else
                begin
                    count_next = STACK_CW'(count_reg - 1'b1);
                end
                state_next = S_POP_L;
            end
            S_POP_L:
            begin
                rhs_next   = empty_reg ? '1 : mem_q_reg;
                empty_next = (count_reg == '0);
                if (count_reg == '0)
                begin
                    err_next = note_err(err_reg, ERR_UNDER);
                end
                else
                begin
                    count_next = STACK_CW'(count_reg - 1'b1);
                end
                state_next = S_LOAD_L;
            end
            S_LOAD_L:
            begin
                lhs_next   = empty_reg ? '1 : mem_q_reg;
                state_next = S_ALU;
            end
            S_ALU:
            begin
                state_next = S_PUSH;
                unique case (cmd_reg.op)
                    OP_ADD: res_next = lhs_reg + rhs_reg;
                    OP_SUB: res_next = lhs_reg - rhs_reg;
                    OP_MUL: res_next = lhs_reg * rhs_reg;
                    OP_DIV:
                    begin
                        if (rhs_reg == '0)
                        begin
                            res_next = '0;
                            err_next = note_err(err_reg, ERR_DIV0);
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            neg_next      = lhs_reg[DATA_W-1] ^ rhs_reg[DATA_W-1];
                            state_next    = S_DIV;
                        end
                    end
                    default: res_next = res_reg;
                endcase
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = neg_reg ? (DATA_W'(0) - div_rsp.quotient) : div_rsp.quotient;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (count_reg >= STACK_CW'(STACK_DEPTH))
                begin
                    err_next = note_err(err_reg, ERR_OVER);
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = STACK_CW'(count_reg + 1'b1);
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (cmd_reg.last)
                begin
                    empty_next = (count_reg == '0);
                    if (count_reg == '0)
                    begin
                        err_next = note_err(err_reg, ERR_UNDER);
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    value_next        = empty_reg ? '1 : mem_q_reg;
                    error_next        = err_reg;
                    count_next        = '0;
                    err_next          = ERR_NONE;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            err_reg          <= ERR_NONE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            err_reg          <= err_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        empty_reg <= empty_next;
        neg_reg   <= neg_next;
        rhs_reg   <= rhs_next;
        lhs_reg   <= lhs_next;
        res_reg   <= res_next;
        value_reg <= value_next;
        error_reg <= error_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[wr_addr] <= res_reg;
        end
        mem_q_reg <= stack_mem[rd_addr];
    end

    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign error_code   = error_reg;

endmodule

`default_nettype wire

@@ rtl/core/postfix_expression_evaluator.sv @@
// Evaluates a postfix expression fed one ASCII character per item, with last_char set on
// the final character. Digits push 0 to 9; + - * / pop two operands and push the 32-bit
// wrapped result (truncating division); other characters are ignored. On the final
// character one item carries the top of stack (or -1 when empty) and the first error
// seen (1 underflow, 2 divide by zero, 3 overflow), and the stack is cleared. The front
// classifies characters into a four-entry command queue, so input keeps flowing while
// the back end works. The back end holds the 64-entry stack in a RAM with a registered
// read port and runs each command through a sequencer: a digit is pushed and finished;
// an add, subtract or multiply pops the right and left operands, computes and pushes;
// a divide by a nonzero value also waits on the one quotient bit per cycle divider;
// the final character then passes an emit state. The result sits in an output register until taken.
`timescale 1ns / 1ps
`default_nettype none

module postfix_expression_evaluator
    import pee_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               char_valid,
    output logic                    char_stall,
    input  wire logic [7:0]         char_code,
    input  wire logic               last_char,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [31:0]      value,
    output logic [1:0]              error_code
);

    pee_cmd_t          push_data;
    pee_cmd_t          pop_data;
    logic              cmd_push;
    logic              cmd_pop;
    logic              fifo_full;
    logic              fifo_valid;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic [DATA_W-1:0] value_raw;

    pee_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_code  (char_code),
        .last_char  (last_char),
        .cmd_push   (cmd_push),
        .cmd_data   (push_data),
        .cmd_full   (fifo_full)
    );

    pee_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .pop_data  (pop_data),
        .not_empty (fifo_valid)
    );

    pee_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pee_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (fifo_valid),
        .cmd_in       (pop_data),
        .cmd_pop      (cmd_pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value_raw),
        .error_code   (error_code)
    );

    assign value = $signed(value_raw);

`ifndef SYNTHESIS
    a_no_fifo_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_push && fifo_full))
        else $error("command pushed into a full queue");

    a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> fifo_valid)
        else $error("command popped from an empty queue");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(div_rsp.done) |-> $past(div_rsp.busy))
        else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import pee_pkg::*;

    typedef logic [7:0] char_q_t[$];

    typedef struct {
        logic [31:0] value;
        logic [1:0]  err;
    } answer_t;

    class rpn_scoreboard;
        logic [31:0] operands[STACK_DEPTH];
        int unsigned depth;
        logic [1:0]  first_err;
        answer_t     answers[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned err_seen[4];

        function new();
            depth = 0;
            first_err = ERR_NONE;
            mismatches = 0;
            checked = 0;
            foreach (err_seen[i])
            begin
                err_seen[i] = 0;
            end
        endfunction

        function void flag(input logic [1:0] code);
            if (first_err == ERR_NONE)
            begin
                first_err = code;
            end
        endfunction

        function void push(input logic [31:0] v);
            if (depth >= STACK_DEPTH)
            begin
                flag(ERR_OVER);
            end
            else
            begin
                operands[depth] = v;
                depth++;
            end
        endfunction

        function logic [31:0] pop();
            if (depth == 0)
            begin
                flag(ERR_UNDER);
                return '1;
            end
            depth--;
            return operands[depth];
        endfunction

        function logic [31:0] quotient(input logic [31:0] a, input logic [31:0] b);
            logic [31:0] ma;
            logic [31:0] mb;
            logic [31:0] q;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            if (b == 32'd0)
            begin
                flag(ERR_DIV0);
                return 32'd0;
            end
            q = ma / mb;
            return (a[31] != b[31]) ? -q : q;
        endfunction

        function void note_char(input logic [7:0] c, input logic last);
            logic [31:0] rhs;
            logic [31:0] lhs;
            logic [31:0] r;
            answer_t     a;
            if (c >= CH_0 && c <= CH_9)
            begin
                push(32'(c - CH_0));
            end
            else
            begin
                case (c)
                    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH:
                    begin
                        rhs = pop();
                        lhs = pop();
                        case (c)
                            CH_PLUS:  r = lhs + rhs;
                            CH_MINUS: r = lhs - rhs;
                            CH_STAR:  r = lhs * rhs;
                            default:  r = quotient(lhs, rhs);
                        endcase
                        push(r);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (last)
            begin
                if (depth == 0)
                begin
                    flag(ERR_UNDER);
                    a.value = '1;
                end
                else
                begin
                    a.value = operands[depth - 1];
                end
                a.err = first_err;
                answers.push_back(a);
                err_seen[a.err]++;
                depth = 0;
                first_err = ERR_NONE;
            end
        endfunction

        task report(input string what, input logic [31:0] got, input logic [31:0] want);
            $display("MISMATCH at %0t ns: %s got %0h, expected %0h", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(input logic [31:0] v, input logic [1:0] e);
            answer_t a;
            checked++;
            if (answers.size() == 0)
            begin
                report("result with nothing pending, value", v, 32'd0);
            end
            else
            begin
                a = answers.pop_front();
                if (v !== a.value)
                begin
                    report("value", v, a.value);
                end
                if (e !== a.err)
                begin
                    report("error_code", 32'(e), 32'(a.err));
                end
            end
        endtask
    endclass

    logic               clk;
    logic               rst_n = 1'b0;
    logic               char_valid = 1'b0;
    logic               char_stall;
    logic [7:0]         char_code = 8'd0;
    logic               last_char = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic signed [31:0] value;
    logic [1:0]         error_code;

    rpn_scoreboard board;
    int                 burst_left = 0;
    int                 active_sent = 0;
    int                 exprs_sent = 0;
    int                 stall_mode = 0;
    int                 stall_cnt = 0;

    postfix_expression_evaluator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_code    (char_code),
        .last_char    (last_char),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .error_code   (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit is_active(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || c == CH_PLUS || c == CH_MINUS
            || c == CH_STAR || c == CH_SLASH;
    endfunction

    function automatic logic [7:0] digit_char(input int d);
        return CH_0 + 8'(d);
    endfunction

    function automatic logic [7:0] op_char(input int k);
        case (k)
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2, 3:    return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] ignored_char();
        logic [7:0] c;
        do
        begin
            c = 8'($urandom_range(0, 255));
        end
        while (is_active(c));
        return c;
    endfunction

    function automatic char_q_t wellformed_expr(input bit noisy);
        char_q_t e;
        int      pushes_left;
        int      depth;
        pushes_left = $urandom_range(1, 12);
        depth = 0;
        while (pushes_left > 0 || depth > 1)
        begin
            if (noisy && $urandom_range(0, 4) == 0)
            begin
                e.push_back(ignored_char());
            end
            if (pushes_left > 0 && (depth < 2 || $urandom_range(0, 2) != 0))
            begin
                e.push_back(digit_char($urandom_range(0, 9)));
                pushes_left--;
                depth++;
            end
            else
            begin
                e.push_back(op_char($urandom_range(0, 5)));
                depth--;
            end
        end
        if (noisy && $urandom_range(0, 2) == 0)
        begin
            e.push_back(ignored_char());
        end
        return e;
    endfunction

    function automatic char_q_t broken_expr();
        char_q_t e;
        int      n;
        n = $urandom_range(1, 10);
        repeat (n)
        begin
            case ($urandom_range(0, 3))
                0, 1:    e.push_back(digit_char($urandom_range(0, 9)));
                2:       e.push_back(op_char($urandom_range(0, 5)));
                default: e.push_back(ignored_char());
            endcase
        end
        return e;
    endfunction

    function automatic char_q_t overflow_expr();
        char_q_t e;
        int      n;
        n = $urandom_range(STACK_DEPTH, STACK_DEPTH + 4);
        repeat (n)
        begin
            e.push_back(digit_char($urandom_range(0, 9)));
        end
        repeat ($urandom_range(0, 3))
        begin
            e.push_back(op_char($urandom_range(0, 5)));
        end
        return e;
    endfunction

    // Builds 2**31 as 2 * 8**10, divides it by minus one and may step it down by one.
    function automatic char_q_t min_int_expr();
        char_q_t e;
        e.push_back(digit_char(2));
        repeat (10)
        begin
            e.push_back(digit_char(8));
            e.push_back(CH_STAR);
        end
        e.push_back(digit_char(0));
        e.push_back(digit_char(1));
        e.push_back(CH_MINUS);
        e.push_back(CH_SLASH);
        if ($urandom_range(0, 1) == 1)
        begin
            e.push_back(digit_char(1));
            e.push_back(CH_MINUS);
        end
        return e;
    endfunction

    task automatic send_item(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        char_code  <= c;
        last_char  <= last;
        char_valid <= 1'b1;
        @(posedge clk);
        while (char_stall)
        begin
            @(posedge clk);
        end
        board.note_char(c, last);
        if (is_active(c))
        begin
            active_sent++;
        end
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_expr(input char_q_t e);
        foreach (e[i])
        begin
            send_item(e[i], i == e.size() - 1);
        end
        exprs_sent++;
    endtask

    always @(negedge clk)
    begin
        if (stall_cnt == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_cnt  <= $urandom_range(20, 200);
        end
        else
        begin
            stall_cnt <= stall_cnt - 1;
        end
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 2) == 0);
            2:       result_stall <= ((stall_cnt % 7) < 3);
            default: result_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            board.check_result(value, error_code);
        end
    end

    initial
    begin
        char_q_t e;
        int      idx;
        int      kind;
        board = new();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        e = '{digit_char(9)};
        send_expr(e);
        e = '{digit_char(0)};
        send_expr(e);
        e = '{digit_char(8), digit_char(9), CH_MINUS};
        send_expr(e);
        e = '{digit_char(7), digit_char(8), CH_STAR};
        send_expr(e);
        e = '{digit_char(0), digit_char(7), CH_MINUS, digit_char(2), CH_SLASH};
        send_expr(e);
        e = '{CH_PLUS};
        send_expr(e);
        e = '{digit_char(5), digit_char(0), CH_SLASH};
        send_expr(e);
        e = '{8'h00};
        send_expr(e);
        e = '{8'hFF, digit_char(3), 8'h3A, 8'h2C, 8'h2E, digit_char(4), 8'h80, CH_PLUS};
        send_expr(e);
        e = '{digit_char(0), digit_char(0), CH_SLASH, CH_PLUS};
        send_expr(e);

        idx = 0;
        while (active_sent < 450)
        begin
            kind = $urandom_range(0, 39);
            if (idx == 3 || kind == 0)
            begin
                e = overflow_expr();
            end
            else if (idx == 7 || kind == 1)
            begin
                e = min_int_expr();
            end
            else if (kind < 8)
            begin
                e = broken_expr();
            end
            else
            begin
                e = wellformed_expr(kind < 14);
            end
            send_expr(e);
            idx++;
        end
        char_valid <= 1'b0;

        while (board.answers.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (80) @(posedge clk);

        $display("Sent %0d expressions holding %0d digit and operator items; %0d results checked.",
                 exprs_sent, active_sent, board.checked);
        $display("Expected codes: ok %0d, underflow %0d, divide by zero %0d, overflow %0d.",
                 board.err_seen[ERR_NONE], board.err_seen[ERR_UNDER],
                 board.err_seen[ERR_DIV0], board.err_seen[ERR_OVER]);
        if (board.mismatches == 0 && board.answers.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
